// ===== rtl/core/q2e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, types and the CORDIC angle table for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;

    // Q30 working values, with headroom for the CORDIC gain (about 1.65)
    localparam int TW = 34;   // term / cordic datapath width
    localparam int ZW = 34;   // angle accumulator width

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] ONE_Q30     = 34'sd1073741824;

    typedef struct packed {
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cordic;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0: r = 34'sd843314856;
            1: r = 34'sd497837829;
            2: r = 34'sd263043836;
            3: r = 34'sd133525158;
            4: r = 34'sd67021686;
            5: r = 34'sd33543515;
            6: r = 34'sd16775850;
            7: r = 34'sd8388437;
            8: r = 34'sd4194282;
            9: r = 34'sd2097149;
            default: begin
                if (i >= 31) r = '0;
                else r = (34'sd1 <<< (30 - i)) - 34'sd1;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/q2e_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_stream_if
// Valid/ready channel carrying a payload of configurable width.
// ----------------------------------------------------------------------------
interface q2e_stream_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/q2e_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined integer square root, one result bit per stage.
// Input is a 61-bit value, output 31 bits.
// ----------------------------------------------------------------------------
module q2e_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_val,
    output logic [30:0] o_root
);
    localparam int N = 31;
    logic [61:0] r_rem  [N];
    logic [30:0] r_root [N];
    logic [61:0] n_rem  [N];
    logic [30:0] n_root [N];

    // restoring method, bit position 30 - s decided in stage s
    always_comb begin
        for (int s = 0; s < N; s++) begin
            logic [61:0] rem_in;
            logic [30:0] root_in;
            logic [61:0] trial;
            rem_in  = (s == 0) ? {1'b0, i_val} : r_rem[(s == 0) ? 0 : s - 1];
            root_in = (s == 0) ? '0 : r_root[(s == 0) ? 0 : s - 1];
            trial   = ({31'd0, root_in} << (31 - s)) + (62'd1 << (2 * (30 - s)));
            if (rem_in >= trial) begin
                n_rem[s]  = rem_in - trial;
                n_root[s] = root_in | (31'd1 << (30 - s));
            end else begin
                n_rem[s]  = rem_in;
                n_root[s] = root_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < N; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[N-1];
endmodule

// ===== rtl/core/q2e_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_cordic
// Vectoring CORDIC, one micro-rotation per register stage, with the
// quadrant pre-rotation in its first stage.
// ----------------------------------------------------------------------------
module q2e_cordic #(
    parameter int STAGES = q2e_pkg::CORDIC_STAGES
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [q2e_pkg::TW-1:0]    i_y,
    input  logic signed [q2e_pkg::TW-1:0]    i_x,
    output logic signed [q2e_pkg::ZW-1:0]    o_angle
);
    q2e_pkg::t_cordic r_st [STAGES+1];
    q2e_pkg::t_cordic n_st [STAGES+1];

    always_comb begin
        n_st[0].zero = (i_x == '0) && (i_y == '0);
        n_st[0].x = i_x;
        n_st[0].y = i_y;
        n_st[0].z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_st[0].x = i_y;
                n_st[0].y = -i_x;
                n_st[0].z = q2e_pkg::HALF_PI_Q30;
            end else begin
                n_st[0].x = -i_y;
                n_st[0].y = i_x;
                n_st[0].z = -q2e_pkg::HALF_PI_Q30;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            n_st[i+1].zero = r_st[i].zero;
            if (r_st[i].y >= 0) begin
                n_st[i+1].x = r_st[i].x + (r_st[i].y >>> i);
                n_st[i+1].y = r_st[i].y - (r_st[i].x >>> i);
                n_st[i+1].z = r_st[i].z + q2e_pkg::atan_entry(i);
            end else begin
                n_st[i+1].x = r_st[i].x - (r_st[i].y >>> i);
                n_st[i+1].y = r_st[i].y + (r_st[i].x >>> i);
                n_st[i+1].z = r_st[i].z - q2e_pkg::atan_entry(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= STAGES; i++) r_st[i] <= n_st[i];
        end
    end

    assign o_angle = r_st[STAGES].zero ? '0 : r_st[STAGES].z;
endmodule

// ===== rtl/core/quaternion_to_euler_angles_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Quaternion (Q1.15) to Z-Y-X Euler angles (Q3.13 radians), fully pipelined.
// ----------------------------------------------------------------------------
// One quaternion is taken every cycle while the output is not stalled. A
// result passes through the products and terms, the square root (pitch
// path, the others delayed to match), the CORDIC and the output register.
// The whole pipeline advances only when the output register is empty or
// being taken, so a stall on the output holds every item in place.
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    q2e_stream_if.sink   i_quat,
    q2e_stream_if.source o_euler
);
    localparam int TW  = q2e_pkg::TW;
    localparam int ZW  = q2e_pkg::ZW;
    localparam int SQD = 31;
    localparam int LAT = 3 + SQD + 1 + CORDIC_STAGES;

    logic en;
    logic [LAT-1:0] r_vld;
    logic r_ovld;
    assign en = !r_ovld || o_euler.ready;
    assign i_quat.ready = en;

    logic signed [15:0] w, x, y, z;
    assign w = i_quat.data[15:0];
    assign x = i_quat.data[31:16];
    assign y = i_quat.data[47:32];
    assign z = i_quat.data[63:48];

    // stage 1: products, Q30 exactly
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_zz, r_wy, r_zx, r_wz, r_xy;
    // stage 2: terms
    logic signed [TW-1:0] r_sr, r_cr, r_sp, r_sy, r_cy;

    function automatic logic signed [TW-1:0] sat(input logic signed [TW-1:0] v);
        if (v > 34'sd2147483647) return 34'sd2147483647;
        if (v < -34'sd2147483648) return -34'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [TW-1:0] dbl(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [TW-1:0] s;
        s = TW'(a) + TW'(b);
        return s <<< 1;
    endfunction

    // stage 3: clamp decision and 1 - s^2
    logic        r_clp;
    logic        r_neg;
    logic [60:0] r_rem;
    logic signed [TW-1:0] r3_sr, r3_cr, r3_sp, r3_sy, r3_cy;
    logic signed [63:0] sp2;
    // terms are saturated to 32 bits, so the square needs only 32 x 32
    assign sp2 = $signed(r_sp[31:0]) * $signed(r_sp[31:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= w * x;  r_yz <= y * z;  r_xx <= x * x;
            r_yy <= y * y;  r_zz <= z * z;  r_wy <= w * y;
            r_zx <= z * x;  r_wz <= w * z;  r_xy <= x * y;
            r_sr <= sat(dbl(r_wx, r_yz));
            r_cr <= sat(q2e_pkg::ONE_Q30 - dbl(r_xx, r_yy));
            r_sp <= sat(dbl(r_wy, -r_zx));
            r_sy <= sat(dbl(r_wz, r_xy));
            r_cy <= sat(q2e_pkg::ONE_Q30 - dbl(r_yy, r_zz));
            r3_sr <= r_sr; r3_cr <= r_cr; r3_sp <= r_sp; r3_sy <= r_sy; r3_cy <= r_cy;
            r_clp <= (r_sp >= q2e_pkg::ONE_Q30) || (r_sp <= -q2e_pkg::ONE_Q30);
            r_neg <= r_sp[TW-1];
            r_rem <= 61'((64'd1 << 60) - 64'(sp2));
        end
    end

    // align everything with the square root
    logic signed [TW-1:0] r_dsr [SQD], r_dcr [SQD], r_dsp [SQD], r_dsy [SQD], r_dcy [SQD];
    logic r_dclp [SQD], r_dneg [SQD];
    logic [30:0] root;

    q2e_isqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_val(r_rem), .o_root(root));

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < SQD; k++) begin
                r_dsr[k]  <= (k == 0) ? r3_sr : r_dsr[(k == 0) ? 0 : k-1];
                r_dcr[k]  <= (k == 0) ? r3_cr : r_dcr[(k == 0) ? 0 : k-1];
                r_dsp[k]  <= (k == 0) ? r3_sp : r_dsp[(k == 0) ? 0 : k-1];
                r_dsy[k]  <= (k == 0) ? r3_sy : r_dsy[(k == 0) ? 0 : k-1];
                r_dcy[k]  <= (k == 0) ? r3_cy : r_dcy[(k == 0) ? 0 : k-1];
                r_dclp[k] <= (k == 0) ? r_clp : r_dclp[(k == 0) ? 0 : k-1];
                r_dneg[k] <= (k == 0) ? r_neg : r_dneg[(k == 0) ? 0 : k-1];
            end
        end
    end

    logic signed [ZW-1:0] a_roll, a_pitch, a_yaw;
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (.i_clk(i_clk), .i_en(en),
        .i_y(r_dsr[SQD-1]), .i_x(r_dcr[SQD-1]), .o_angle(a_roll));
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (.i_clk(i_clk), .i_en(en),
        .i_y(r_dsp[SQD-1]), .i_x({3'b000, root}), .o_angle(a_pitch));
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (.i_clk(i_clk), .i_en(en),
        .i_y(r_dsy[SQD-1]), .i_x(r_dcy[SQD-1]), .o_angle(a_yaw));

    logic r_cclp [CORDIC_STAGES+1], r_cneg [CORDIC_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                r_cclp[k] <= (k == 0) ? r_dclp[SQD-1] : r_cclp[(k == 0) ? 0 : k-1];
                r_cneg[k] <= (k == 0) ? r_dneg[SQD-1] : r_cneg[(k == 0) ? 0 : k-1];
            end
        end
    end

    localparam int SH = 30 - q2e_pkg::ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] PI_O = (34'sd3373259426 + (34'sd1 <<< (SH-1))) >>> SH;
    localparam logic signed [ZW-1:0] HP_O = (q2e_pkg::HALF_PI_Q30 + (34'sd1 <<< (SH-1))) >>> SH;

    function automatic logic signed [ZW-1:0] cvt(input logic signed [ZW-1:0] a,
                                                 input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] v;
        v = (a + (34'sd1 <<< (SH-1))) >>> SH;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    logic signed [ZW-1:0] p_val;
    always_comb begin
        if (r_cclp[CORDIC_STAGES]) p_val = r_cneg[CORDIC_STAGES] ? -HP_O : HP_O;
        else p_val = cvt(a_pitch, HP_O);
    end

    logic [47:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[LAT-2:0], i_quat.valid};
            r_ovld <= r_vld[LAT-1];
        end
        if (en) begin
            r_out <= {r_cclp[CORDIC_STAGES], 16'(cvt(a_yaw, PI_O)), 15'(p_val),
                      16'(cvt(a_roll, PI_O))};
        end
    end

    assign o_euler.valid = r_ovld;
    assign o_euler.data  = r_out;
endmodule

// ===== tb/sv/tb_q2e_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q2e_checker
// Watches the quaternion and Euler angle channels, computes the expected
// angles for every accepted quaternion and compares them, in order, with
// the angles the block returns.
// ----------------------------------------------------------------------------
module tb_q2e_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_quat_valid,
    input  logic        i_quat_ready,
    input  logic [63:0] i_quat_data,
    input  logic        i_euler_valid,
    input  logic        i_euler_ready,
    input  logic [47:0] i_euler_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic               clamped;
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } t_euler;

    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HPI_Q30  = 64'sd1686629713;
    localparam longint ONE      = 64'sd1073741824;
    localparam longint TERM_MAX = 64'sd2147483647;
    localparam longint TERM_MIN = -64'sd2147483648;

    t_euler angles_due[$];

    function automatic longint sat_term(input longint v);
        if (v > TERM_MAX) return TERM_MAX;
        if (v < TERM_MIN) return TERM_MIN;
        return v;
    endfunction

    function automatic longint angle_entry(input int i);
        longint tbl [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return tbl[i];
        if (i >= 31) return 0;
        return (64'sd1 <<< (30 - i)) - 1;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring rotation: angle of (cx, sy) in Q30
    function automatic longint vector_angle(input longint sy, input longint cx);
        longint xv, yv, zv, nx, dx, dy;
        xv = cx;
        yv = sy;
        zv = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                nx = yv; yv = -xv; xv = nx; zv = HPI_Q30;
            end else begin
                nx = -yv; yv = xv; xv = nx; zv = -HPI_Q30;
            end
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv += dx; yv -= dy; zv += angle_entry(i);
            end else begin
                xv -= dx; yv += dy; zv -= angle_entry(i);
            end
        end
        return zv;
    endfunction

    function automatic longint q30_to_angle(input longint v);
        return (v + (64'sd1 <<< (29 - q2e_pkg::ANGLE_FRAC_BITS)))
               >>> (30 - q2e_pkg::ANGLE_FRAC_BITS);
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_euler euler_of(input logic [63:0] q);
        longint w, x, y, z, sr, cr, sp, sy, cy, pi_o, hpi_o, c;
        t_euler r;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        pi_o  = q30_to_angle(PI_Q30);
        hpi_o = q30_to_angle(HPI_Q30);
        sr = sat_term(2 * (w * x + y * z));
        cr = sat_term(ONE - 2 * (x * x + y * y));
        sp = sat_term(2 * (w * y - z * x));
        sy = sat_term(2 * (w * z + x * y));
        cy = sat_term(ONE - 2 * (y * y + z * z));
        r.roll = 16'(clamp_sym(q30_to_angle(vector_angle(sr, cr)), pi_o));
        r.yaw  = 16'(clamp_sym(q30_to_angle(vector_angle(sy, cy)), pi_o));
        if (sp >= ONE) begin
            r.pitch = 15'(hpi_o);
            r.clamped = 1'b1;
        end else if (sp <= -ONE) begin
            r.pitch = 15'(-hpi_o);
            r.clamped = 1'b1;
        end else begin
            c = longint'(int_sqrt((64'd1 << 60) - longint'(sp * sp)));
            r.pitch = 15'(clamp_sym(q30_to_angle(vector_angle(sp, c)), hpi_o));
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_euler got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_euler_valid && i_euler_ready) begin
                got = t_euler'(i_euler_data);
                if (angles_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_euler_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = angles_due.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch expected roll %0d pitch %0d yaw %0d ",
                                  "clamp %0b, actual roll %0d pitch %0d yaw %0d clamp %0b"},
                                 $time, want.roll, want.pitch, want.yaw, want.clamped,
                                 got.roll, got.pitch, got.yaw, got.clamped);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_quat_valid && i_quat_ready)
                angles_due.push_back(euler_of(i_quat_data));
            o_pending <= angles_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_quaternion_to_euler_angles_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top
// Drives directed and random quaternions into the converter with random
// gaps and output stalls; the checker compares every set of angles.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_top;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   no_stall;

    q2e_stream_if #(.W(64)) quat_ch ();
    q2e_stream_if #(.W(48)) euler_ch ();

    quaternion_to_euler_angles_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch),
        .o_euler (euler_ch)
    );

    tb_q2e_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_quat_valid  (quat_ch.valid),
        .i_quat_ready  (quat_ch.ready),
        .i_quat_data   (quat_ch.data),
        .i_euler_valid (euler_ch.valid),
        .i_euler_ready (euler_ch.ready),
        .i_euler_data  (euler_ch.data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // w occupies the low bits of the transfer, z the high bits
    task automatic send_quat(input logic [15:0] w, x, y, z, input int gap);
        if (gap > 0) begin
            quat_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        quat_ch.valid = 1'b1;
        quat_ch.data  = {z, y, x, w};
        @(posedge i_clk);
        while (!quat_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int draw_gap();
        return no_stall ? 0 : $urandom_range(0, 17);
    endfunction

    // output side: random stall before each transfer
    initial begin
        euler_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = draw_gap();
            if (stall > 0) begin
                euler_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            euler_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!euler_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [15:0] dir [][4];
        int          wait_cycles;
        no_stall      = 1'b0;
        quat_ch.valid = 1'b0;
        quat_ch.data  = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        dir = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000},
            '{16'h8000, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000},
            '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000},
            '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
            '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
            '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
            '{16'h0000, 16'h4000, 16'h4000, 16'h0000},  // both roll terms zero
            '{16'h0000, 16'h0000, 16'h4000, 16'h4000},  // both yaw terms zero
            '{16'h5A82, 16'h0000, 16'h5A82, 16'h0000},  // pitch near +pi/2
            '{16'h5A82, 16'h0000, 16'hA57E, 16'h0000},  // pitch near -pi/2
            '{16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000},  // pitch term above one, pitch clamped
            '{16'h7FFF, 16'h0000, 16'h8000, 16'h0000},
            '{16'h5A82, 16'h5A82, 16'h0000, 16'h0000},  // roll pi/2
            '{16'h0000, 16'h0000, 16'h0000, 16'h8000},  // negative cosine, yaw pi
            '{16'h0100, 16'h7F00, 16'h0000, 16'h0000},  // roll near pi
            '{16'h0100, 16'h7F00, 16'h0000, 16'hFF00},
            '{16'h4000, 16'h4000, 16'h4000, 16'h4000},
            '{16'hC000, 16'h4000, 16'hC000, 16'h4000},
            '{16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF}
        };
        foreach (dir[i]) send_quat(dir[i][0], dir[i][1], dir[i][2], dir[i][3], draw_gap());

        for (int n = 0; n < 1250; n++) begin
            logic [15:0] c [4];
            if (n % 200 == 0) no_stall = ($urandom_range(0, 2) == 0);
            if (n == 600) begin
                // drain the pipeline completely before carrying on
                quat_ch.valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            case ($urandom_range(0, 3))
                0: foreach (c[k]) c[k] = 16'($urandom);
                1: foreach (c[k]) c[k] = 16'($signed($urandom_range(0, 32767)) - 16384);
                2: begin
                    // near-unit: one dominant component, small others
                    foreach (c[k]) c[k] = 16'($signed($urandom_range(0, 4095)) - 2048);
                    c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'h7F00 : 16'h8100;
                end
                default: begin
                    // pitch term near plus or minus one
                    c[0] = 16'($urandom_range(23000, 23300));
                    c[2] = $urandom_range(0, 1) ? 16'($urandom_range(23000, 23300))
                                                : -16'($urandom_range(23000, 23300));
                    c[1] = 16'($signed($urandom_range(0, 255)) - 128);
                    c[3] = 16'($signed($urandom_range(0, 255)) - 128);
                end
            endcase
            send_quat(c[0], c[1], c[2], c[3], draw_gap());
        end
        quat_ch.valid = 1'b0;
        no_stall = 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (80) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
